// File: sv/scle_pkg.sv
package scle_pkg;

	localparam int LINE_MAX = 32;
	localparam int LEN_W    = $clog2(LINE_MAX);
	localparam int CHAR_W   = 8;
	localparam int DEST_W   = 2;
	localparam int ERASE_W  = 3;

	localparam logic [CHAR_W-1:0] KEY_CR     = 8'h0d;
	localparam logic [CHAR_W-1:0] KEY_LF     = 8'h0a;
	localparam logic [CHAR_W-1:0] KEY_BS     = 8'h7f;
	localparam logic [CHAR_W-1:0] KEY_ESC    = 8'h1b;
	localparam logic [CHAR_W-1:0] KEY_PROMPT = 8'h3e;

	localparam logic [DEST_W-1:0] DEST_ECHO = 2'd0;
	localparam logic [DEST_W-1:0] DEST_CMD  = 2'd1;
	localparam logic [DEST_W-1:0] DEST_END  = 2'd2;

	localparam logic [ERASE_W-1:0] ERASE_LAST = 3'd5;

	// Source of the byte loaded into the result register.
	typedef enum logic [2:0] {
		SRC_CHAR,
		SRC_CR,
		SRC_LF,
		SRC_ERASE,
		SRC_STORE,
		SRC_LEN,
		SRC_PROMPT
	} src_t;

	typedef struct packed {
		logic take;
		logic emit;
		src_t src;
		logic last;
		logic store_wr;
		logic len_inc;
		logic len_dec;
		logic len_clr;
		logic esc_set;
		logic esc_clr;
		logic idx_clr;
		logic idx_inc;
		logic er_clr;
		logic er_inc;
	} cmd_t;

	typedef struct packed {
		logic is_cr;
		logic is_bs;
		logic is_esc;
		logic is_letter;
		logic in_esc;
		logic len_zero;
		logic len_full;
		logic idx_at_len;
		logic erase_done;
		logic out_free;
	} status_t;

	// Cursor left then erase to end of line.
	function automatic logic [CHAR_W-1:0] erase_byte(input logic [ERASE_W-1:0] idx);
		logic [CHAR_W-1:0] b;
		case (idx)
			3'd0:    b = 8'h1b;
			3'd1:    b = 8'h5b;
			3'd2:    b = 8'h44;
			3'd3:    b = 8'h1b;
			3'd4:    b = 8'h5b;
			3'd5:    b = 8'h4b;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: sv/scle_dp.sv
module scle_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scle_pkg::cmd_t               cmd,
	output scle_pkg::status_t            st,
	input  logic [scle_pkg::CHAR_W-1:0]  rx_char,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [scle_pkg::DEST_W-1:0]  dest,
	output logic [scle_pkg::CHAR_W-1:0]  data,
	output logic                         last
);
	import scle_pkg::*;

	logic [CHAR_W-1:0]  char_q;
	logic [CHAR_W-1:0]  store_q [LINE_MAX];
	logic [CHAR_W-1:0]  rd_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   idx_q;
	logic [ERASE_W-1:0] er_q;
	logic               esc_q;
	logic               valid_q;
	logic [DEST_W-1:0]  dest_q;
	logic [CHAR_W-1:0]  data_q;
	logic               last_q;
	logic [DEST_W-1:0]  dest_d;
	logic [CHAR_W-1:0]  data_d;

	always_ff @(posedge clk) begin
		if (cmd.take)
			char_q <= rx_char;
	end

	// Line store: one write port at the current length, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store_wr)
			store_q[len_q] <= char_q;
		rd_q <= store_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
			er_q  <= '0;
			esc_q <= 1'b0;
		end else begin
			if (cmd.len_clr)
				len_q <= '0;
			else if (cmd.len_inc)
				len_q <= len_q + LEN_W'(1);
			else if (cmd.len_dec)
				len_q <= len_q - LEN_W'(1);
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + LEN_W'(1);
			if (cmd.er_clr)
				er_q <= '0;
			else if (cmd.er_inc)
				er_q <= er_q + ERASE_W'(1);
			if (cmd.esc_set)
				esc_q <= 1'b1;
			else if (cmd.esc_clr)
				esc_q <= 1'b0;
		end
	end

	always_comb begin
		dest_d = DEST_ECHO;
		data_d = char_q;
		case (cmd.src)
			SRC_CHAR:   data_d = char_q;
			SRC_CR:     data_d = KEY_CR;
			SRC_LF:     data_d = KEY_LF;
			SRC_ERASE:  data_d = erase_byte(er_q);
			SRC_STORE: begin
				dest_d = DEST_CMD;
				data_d = rd_q;
			end
			SRC_LEN: begin
				dest_d = DEST_END;
				data_d = CHAR_W'(len_q);
			end
			SRC_PROMPT: data_d = KEY_PROMPT;
			default:    data_d = char_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.emit)
			valid_q <= 1'b1;
		else if (!res_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dest_q <= dest_d;
			data_q <= data_d;
			last_q <= cmd.last;
		end
	end

	assign res_valid = valid_q;
	assign dest      = dest_q;
	assign data      = data_q;
	assign last      = last_q;

	assign st.is_cr      = (char_q == KEY_CR);
	assign st.is_bs      = (char_q == KEY_BS);
	assign st.is_esc     = (char_q == KEY_ESC);
	assign st.is_letter  = (char_q >= 8'h41 && char_q <= 8'h5a) ||
	                       (char_q >= 8'h61 && char_q <= 8'h7a);
	assign st.in_esc     = esc_q;
	assign st.len_zero   = (len_q == '0);
	assign st.len_full   = (len_q == LEN_W'(LINE_MAX - 1));
	assign st.idx_at_len = (idx_q == len_q);
	assign st.erase_done = (er_q == ERASE_LAST);
	assign st.out_free   = !valid_q || !res_stall;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_MAX - 1))
		else $error("line length beyond capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!valid_q || !res_stall))
		else $error("result register overwritten while held");

	a_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.len_dec |-> len_q != '0)
		else $error("backspace on an empty line changed the length");

	a_wr_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_wr |=> len_q != '0)
		else $error("store write did not grow the line");

endmodule

// File: sv/scle_ctrl.sv
module scle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  scle_pkg::status_t st,
	output scle_pkg::cmd_t    cmd
);
	import scle_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ERASE,
		ST_LF,
		ST_CMD_RD,
		ST_CMD_EMIT,
		ST_END,
		ST_PROMPT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.src = SRC_CHAR;
		case (state_q)
			ST_IDLE: begin
				if (rx_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (st.in_esc) begin
					cmd.esc_clr = st.is_letter;
					state_d     = ST_IDLE;
				end else if (st.is_cr) begin
					if (st.out_free) begin
						cmd.emit    = 1'b1;
						cmd.src     = SRC_CR;
						cmd.idx_clr = 1'b1;
						state_d     = ST_LF;
					end
				end else if (st.is_bs) begin
					if (!st.len_zero) begin
						cmd.len_dec = 1'b1;
						cmd.er_clr  = 1'b1;
						state_d     = ST_ERASE;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (st.is_esc) begin
					cmd.esc_set = 1'b1;
					state_d     = ST_IDLE;
				end else if (st.len_full) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.store_wr = 1'b1;
					cmd.len_inc  = 1'b1;
					cmd.emit     = 1'b1;
					cmd.src      = SRC_CHAR;
					cmd.last     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ERASE: begin
				if (st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.src    = SRC_ERASE;
					cmd.last   = st.erase_done;
					cmd.er_inc = 1'b1;
					if (st.erase_done)
						state_d = ST_IDLE;
				end
			end
			ST_LF: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_LF;
					state_d  = ST_CMD_RD;
				end
			end
			// The store read is registered, so each command byte is read in ST_CMD_RD before ST_CMD_EMIT sends it.
			ST_CMD_RD: begin
				state_d = st.idx_at_len ? ST_END : ST_CMD_EMIT;
			end
			ST_CMD_EMIT: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.src     = SRC_STORE;
					cmd.idx_inc = 1'b1;
					state_d     = ST_CMD_RD;
				end
			end
			ST_END: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_LEN;
					state_d  = ST_PROMPT;
				end
			end
			ST_PROMPT: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.src     = SRC_PROMPT;
					cmd.last    = 1'b1;
					cmd.len_clr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign rx_stall = (state_q != ST_IDLE);

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == ST_DECODE)
		else $error("accepted character not decoded");

	a_esc_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECODE && st.in_esc) |-> !cmd.emit && state_d == ST_IDLE)
		else $error("character inside an escape sequence produced a result");

	a_prompt_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROMPT && cmd.emit) |-> cmd.last && cmd.len_clr)
		else $error("prompt did not close the line");

endmodule

// File: sv/serial_console_line_editor.sv
// Serial console line editor.
// The rx channel (rx_valid, rx_stall, rx_char) takes one received console byte per
// transfer; rx_stall is high from the transfer until all results of that byte have
// been loaded into the result register. The res channel (res_valid, res_stall, dest,
// data, last) carries echo bytes (dest 0), command bytes (dest 1) and a command end
// with the line length (dest 2); last marks the final result of one received byte.
// An ordinary byte's echo is loaded into the result register from the decode state,
// after which the next byte can be taken. Escape sequence bytes, a backspace on an
// empty line and bytes arriving on a full line give no result. A backspace gives six
// results at one per cycle while the result register is free. A carriage return
// gives CR, LF, the command bytes (each first read from the line store, which has a
// registered read port), the command end and the prompt. A single result register
// separates the sides; while a held result is stalled by res_stall the sequencer
// waits and the held result stays unchanged.
// Reset empties the line, leaves escape mode and drops any pending result; the line
// store itself is not cleared, as only written entries are ever read.
module serial_console_line_editor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rx_valid,
	output logic                         rx_stall,
	input  logic [scle_pkg::CHAR_W-1:0]  rx_char,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [scle_pkg::DEST_W-1:0]  dest,
	output logic [scle_pkg::CHAR_W-1:0]  data,
	output logic                         last
);
	import scle_pkg::*;

	cmd_t    cmd;
	status_t st;

	scle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.st       (st),
		.cmd      (cmd)
	);

	scle_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.rx_char   (rx_char),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.dest      (dest),
		.data      (data),
		.last      (last)
	);

endmodule

// File: sim/serial_console_line_editor_tb.sv
`timescale 1ns / 100ps

module serial_console_line_editor_tb;

	import scle_pkg::*;

	typedef struct packed {
		logic [DEST_W-1:0] dest;
		logic [CHAR_W-1:0] data;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		bit                typed;
		bit                has_res;
		out_item_t         res;
	} dir_row_t;

	localparam out_item_t NO_RES = '{DEST_ECHO, 8'h00, 1'b0};
	localparam logic [CHAR_W-1:0] ERASE_SEQ [0:5] =
		'{KEY_ESC, 8'h5b, 8'h44, KEY_ESC, 8'h5b, 8'h4b};
	localparam int PHASE_ITEMS = 68;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              rx_valid  = 1'b0;
	logic              rx_stall;
	logic [CHAR_W-1:0] rx_char   = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [DEST_W-1:0] dest;
	logic [CHAR_W-1:0] data;
	logic              last;

	// Shadow of the editor state.
	logic [CHAR_W-1:0] line_mem [0:LINE_MAX-1];
	logic [LEN_W-1:0]  line_len = '0;
	logic              in_esc   = 1'b0;

	out_item_t         awaited_out [$];
	logic [CHAR_W-1:0] keystrokes [$];
	int                tx_gap_pct    = 0;
	int                res_stall_pct = 0;
	int                n_err         = 0;
	int                landed        = 0;

	// Directed keystrokes; rows with a typed result give at most one result.
	dir_row_t dir_rows [0:24] = '{
		'{KEY_CR,  1'b0, 1'b0, NO_RES},
		'{8'h00,   1'b1, 1'b1, '{DEST_ECHO, 8'h00, 1'b1}},
		'{8'hff,   1'b1, 1'b1, '{DEST_ECHO, 8'hff, 1'b1}},
		'{KEY_BS,  1'b0, 1'b0, NO_RES},
		'{KEY_BS,  1'b0, 1'b0, NO_RES},
		'{KEY_BS,  1'b1, 1'b0, NO_RES},
		'{8'h61,   1'b1, 1'b1, '{DEST_ECHO, 8'h61, 1'b1}},
		'{KEY_ESC, 1'b1, 1'b0, NO_RES},
		'{KEY_CR,  1'b1, 1'b0, NO_RES},
		'{KEY_BS,  1'b1, 1'b0, NO_RES},
		'{KEY_ESC, 1'b1, 1'b0, NO_RES},
		'{8'h40,   1'b1, 1'b0, NO_RES},
		'{8'h60,   1'b1, 1'b0, NO_RES},
		'{8'h5b,   1'b1, 1'b0, NO_RES},
		'{8'h7b,   1'b1, 1'b0, NO_RES},
		'{8'h5a,   1'b1, 1'b0, NO_RES},
		'{8'h7a,   1'b1, 1'b1, '{DEST_ECHO, 8'h7a, 1'b1}},
		'{KEY_ESC, 1'b1, 1'b0, NO_RES},
		'{8'h61,   1'b1, 1'b0, NO_RES},
		'{8'h41,   1'b1, 1'b1, '{DEST_ECHO, 8'h41, 1'b1}},
		'{8'h7e,   1'b1, 1'b1, '{DEST_ECHO, 8'h7e, 1'b1}},
		'{KEY_CR,  1'b0, 1'b0, NO_RES},
		'{KEY_ESC, 1'b1, 1'b0, NO_RES},
		'{8'h41,   1'b1, 1'b0, NO_RES},
		'{KEY_CR,  1'b0, 1'b0, NO_RES}
	};

	serial_console_line_editor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_char   (rx_char),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.dest      (dest),
		.data      (data),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_letter(input logic [CHAR_W-1:0] b);
		return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
	endfunction

	// Updates the shadow state for one keystroke and returns the number of
	// results it causes; they are queued only when keep is set.
	function automatic int apply_keystroke(input logic [CHAR_W-1:0] ch, input bit keep);
		out_item_t seq [$];
		if (in_esc) begin
			if (is_letter(ch))
				in_esc = 1'b0;
			return 0;
		end
		if (ch == KEY_CR) begin
			seq.push_back('{DEST_ECHO, KEY_CR, 1'b0});
			seq.push_back('{DEST_ECHO, KEY_LF, 1'b0});
			for (int i = 0; i < int'(line_len); i++)
				seq.push_back('{DEST_CMD, line_mem[i], 1'b0});
			seq.push_back('{DEST_END, CHAR_W'(line_len), 1'b0});
			seq.push_back('{DEST_ECHO, KEY_PROMPT, 1'b0});
			line_len = '0;
		end else if (ch == KEY_BS) begin
			if (line_len != 0) begin
				line_len = line_len - LEN_W'(1);
				for (int i = 0; i < 6; i++)
					seq.push_back('{DEST_ECHO, ERASE_SEQ[i], 1'b0});
			end
		end else if (ch == KEY_ESC) begin
			in_esc = 1'b1;
		end else if (int'(line_len) + 1 < LINE_MAX) begin
			line_mem[line_len] = ch;
			line_len = line_len + LEN_W'(1);
			seq.push_back('{DEST_ECHO, ch, 1'b0});
		end
		if (seq.size() > 0)
			seq[seq.size()-1].last = 1'b1;
		if (keep)
			foreach (seq[i])
				awaited_out.push_back(seq[i]);
		return seq.size();
	endfunction

	function automatic logic [CHAR_W-1:0] text_byte();
		logic [CHAR_W-1:0] b;
		do begin
			if ($urandom_range(0, 3) == 0)
				b = CHAR_W'($urandom_range(0, 255));
			else
				b = CHAR_W'($urandom_range(8'h20, 8'h7e));
		end while (b == KEY_CR || b == KEY_BS || b == KEY_ESC);
		return b;
	endfunction

	// Queues one burst of keystrokes: mostly whole lines ended by CR, some
	// escape sequences and a little noise. A fill burst fills the line and may overrun it.
	function automatic void plan_burst(input bit fill);
		int n;
		int kind;
		logic [CHAR_W-1:0] b;
		kind = fill ? 0 : $urandom_range(0, 9);
		if (kind <= 5) begin
			if (fill)
				n = $urandom_range(LINE_MAX - 1, LINE_MAX + 2);
			else if ($urandom_range(0, 7) == 0)
				n = $urandom_range(LINE_MAX - 6, LINE_MAX + 4);
			else
				n = $urandom_range(0, 6);
			repeat (n) begin
				if (!fill && $urandom_range(0, 5) == 0)
					keystrokes.push_back(KEY_BS);
				else
					keystrokes.push_back(text_byte());
			end
			keystrokes.push_back(KEY_CR);
		end else if (kind <= 7) begin
			keystrokes.push_back(KEY_ESC);
			repeat ($urandom_range(0, 3)) begin
				do b = CHAR_W'($urandom_range(0, 255)); while (is_letter(b));
				keystrokes.push_back(b);
			end
			do b = CHAR_W'($urandom_range(8'h41, 8'h7a)); while (!is_letter(b));
			keystrokes.push_back(b);
		end else begin
			repeat ($urandom_range(1, 3))
				keystrokes.push_back(CHAR_W'($urandom_range(0, 255)));
		end
	endfunction

	// Returns at the clock edge on which the transfer took place.
	task automatic send_byte(input logic [CHAR_W-1:0] ch);
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_char  <= ch;
		do @(posedge clk); while (rx_stall !== 1'b0);
	endtask

	task automatic drain_results();
		rx_valid <= 1'b0;
		while (awaited_out.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : res_check
		out_item_t want;
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (awaited_out.size() == 0) begin
				n_err++;
				$display("%0t: expected no result, got dest %0d data %h last %0d",
					$time, dest, data, last);
			end else begin
				want = awaited_out.pop_front();
				if (dest !== want.dest || data !== want.data || last !== want.last) begin
					n_err++;
					$display("%0t: expected dest %0d data %h last %0d, got dest %0d data %h last %0d",
						$time, want.dest, want.data, want.last, dest, data, last);
				end
			end
		end
		res_stall <= ($urandom_range(0, 99) < res_stall_pct);
	end

	initial begin
		logic [CHAR_W-1:0] ch;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		tx_gap_pct    = 23;
		res_stall_pct = 69;
		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].ch);
			void'(apply_keystroke(dir_rows[i].ch, !dir_rows[i].typed));
			if (dir_rows[i].typed && dir_rows[i].has_res)
				awaited_out.push_back(dir_rows[i].res);
		end
		drain_results();

		for (int ph = 0; ph < 3; ph++) begin
			tx_gap_pct    = (ph == 0) ? 23 : (ph == 1) ? 69 : 0;
			res_stall_pct = (ph == 0) ? 69 : (ph == 1) ? 23 : 0;
			plan_burst(1'b1);
			while (landed < PHASE_ITEMS * (ph + 1) || keystrokes.size() != 0) begin
				if (keystrokes.size() == 0)
					plan_burst(1'b0);
				ch = keystrokes.pop_front();
				send_byte(ch);
				void'(apply_keystroke(ch, 1'b1));
				landed++;
			end
			// Hold the sender back until every result of the phase has gone out.
			drain_results();
		end

		repeat (100) @(posedge clk);
		if (n_err == 0)
			$display("serial_console_line_editor_tb OK");
		else
			$display("serial_console_line_editor_tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("serial_console_line_editor_tb NOT OK");
		$finish;
	end

endmodule
